>>> sv/assert_macros.svh
// Assertion helpers for the parser RTL.
// Each helper expects a signal named clk, and ASSERT_CLK also arst_n, in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge, and skip the check while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every rising clock edge, including the edges seen during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/fsfp_pkg.sv
package fsfp_pkg;

	localparam logic [7:0] SYNC_BYTE  = 8'hAA;
	localparam logic [7:0] FUNC_LIMIT = 8'hF1;

	localparam logic [7:0] FUNC_FLOW     = 8'h51;
	localparam logic [7:0] FUNC_ALT      = 8'h52;
	localparam logic [7:0] FUNC_IMU      = 8'h53;
	localparam logic [7:0] FUNC_ATTITUDE = 8'h54;

	localparam logic [3:0] KIND_UNKNOWN    = 4'd0;
	localparam logic [3:0] KIND_RAW_FLOW   = 4'd1;
	localparam logic [3:0] KIND_FUSED_FLOW = 4'd2;
	localparam logic [3:0] KIND_RAW_ALT    = 4'd3;
	localparam logic [3:0] KIND_FUSED_ALT  = 4'd4;
	localparam logic [3:0] KIND_RAW_IMU    = 4'd5;
	localparam logic [3:0] KIND_FILT_IMU   = 4'd6;
	localparam logic [3:0] KIND_EULER      = 4'd7;
	localparam logic [3:0] KIND_QUAT       = 4'd8;

	localparam int HEAD_DEPTH = 13;
	localparam int HEAD_IDX_W = $clog2(HEAD_DEPTH);
	localparam int LEN_W      = 6;
	localparam int N_VALUES   = 6;

	// Frame queue between the parser and the decoder; depth is a power of two.
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SYNC2,
		PH_FUNC,
		PH_LEN,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	typedef struct packed {
		logic [7:0]                  func;
		logic [LEN_W-1:0]            len;
		logic [HEAD_DEPTH-1:0][7:0]  head;
	} frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} push_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} pop_t;

	typedef struct packed {
		logic [7:0]                  func_code;
		logic [7:0]                  sub_format;
		logic [3:0]                  kind;
		logic [LEN_W-1:0]            payload_length;
		logic [7:0]                  quality;
		logic [7:0]                  light_level;
		logic [N_VALUES-1:0][15:0]   value;
	} result_t;

	function automatic logic [15:0] be16(logic [HEAD_DEPTH-1:0][7:0] head, int pos);
		return {head[pos], head[pos+1]};
	endfunction

	function automatic logic [15:0] sext8(logic [7:0] b);
		return {{8{b[7]}}, b};
	endfunction

	function automatic result_t decode_frame(frame_t f);
		result_t    r;
		logic [7:0] sub;
		sub              = f.head[0];
		r                = '0;
		r.func_code      = f.func;
		r.sub_format     = sub;
		r.payload_length = f.len;
		r.kind           = KIND_UNKNOWN;
		if (sub <= 8'd1) begin
			unique case (f.func)
				FUNC_FLOW: begin
					r.quality = f.head[1];
					if (sub == 8'd0) begin
						r.kind        = KIND_RAW_FLOW;
						r.value[0]    = sext8(f.head[2]);
						r.value[1]    = sext8(f.head[3]);
						r.light_level = f.head[4];
					end else begin
						r.kind        = KIND_FUSED_FLOW;
						for (int i = 0; i < 4; i++)
							r.value[i] = be16(f.head, 2 + 2 * i);
						r.light_level = f.head[10];
					end
				end
				FUNC_ALT: begin
					r.kind     = sub[0] ? KIND_FUSED_ALT : KIND_RAW_ALT;
					r.value[0] = be16(f.head, 1);
				end
				FUNC_IMU: begin
					r.kind = sub[0] ? KIND_FILT_IMU : KIND_RAW_IMU;
					for (int i = 0; i < 6; i++)
						r.value[i] = be16(f.head, 1 + 2 * i);
				end
				FUNC_ATTITUDE: begin
					r.kind = sub[0] ? KIND_QUAT : KIND_EULER;
					for (int i = 0; i < 3; i++)
						r.value[i] = be16(f.head, 1 + 2 * i);
					if (sub[0])
						r.value[3] = be16(f.head, 7);
				end
				default: r.kind = KIND_UNKNOWN;
			endcase
		end
		return r;
	endfunction

endpackage

>>> sv/flow_sensor_frame_parser.sv
// Frame parser for an optical-flow sensor byte stream.
// Input channel: in_valid / in_ready / rx_byte, one received byte per request.
// Output channel: out_valid / out_ready and one port per decoded field; one
// request per frame whose 8-bit sum checksum matches.
// A frame is 0xAA 0xAA, function (< 0xF1), length (1..MAX_PAYLOAD), payload,
// checksum. Bytes that break the expected phase return the hunt to idle.
// Throughput: one byte per cycle. in_ready drops only on a checksum byte while
// the two-entry frame queue is full, i.e. when two frames already wait behind
// a result that the receiver has not taken.
// Path of a result: the edge that accepts the checksum byte writes the frame
// into the queue; once it is at the queue head and the output register is
// empty or being drained, it moves through the decoder into that register.
// A stalled receiver holds the output register; finished frames pile up in
// the queue while the parser keeps taking payload bytes.
// Reset: hunt returns to idle, queue empties, out_valid drops. No clearing
// pass is needed; the payload head is zeroed at every length byte.
module flow_sensor_frame_parser #(
	parameter int MAX_PAYLOAD = 44
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         func_code,
	output logic [7:0]         sub_format,
	output logic [3:0]         kind,
	output logic [5:0]         payload_length,
	output logic [7:0]         quality,
	output logic [7:0]         light_level,
	output logic signed [15:0] value0,
	output logic signed [15:0] value1,
	output logic signed [15:0] value2,
	output logic signed [15:0] value3,
	output logic signed [15:0] value4,
	output logic signed [15:0] value5
);
	import fsfp_pkg::*;

	push_t   push;
	pop_t    q_head;
	logic    q_full;
	logic    pop;
	result_t result;

	// Front: hunt for sync, track sum and capture the payload head.
	fsfp_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte (rx_byte),
		.q_full  (q_full),
		.push    (push)
	);

	// Queue of checked frames; decouples parsing from the receiver.
	fsfp_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (q_full),
		.head  (q_head),
		.pop   (pop)
	);

	// Back: decode the frame kind and fields into the output register.
	fsfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result   (result)
	);

	assign func_code      = result.func_code;
	assign sub_format     = result.sub_format;
	assign kind           = result.kind;
	assign payload_length = result.payload_length;
	assign quality        = result.quality;
	assign light_level    = result.light_level;
	assign value0         = $signed(result.value[0]);
	assign value1         = $signed(result.value[1]);
	assign value2         = $signed(result.value[2]);
	assign value3         = $signed(result.value[3]);
	assign value4         = $signed(result.value[4]);
	assign value5         = $signed(result.value[5]);

endmodule

>>> sv/fsfp_front.sv
module fsfp_front #(
	parameter int MAX_PAYLOAD = 44
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      rx_byte,
	input  logic            q_full,
	output fsfp_pkg::push_t push
);
	import fsfp_pkg::*;

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	phase_t                     phase_q, phase_d;
	logic [LEN_W-1:0]           remain_q;
	logic [LEN_W-1:0]           index_q;
	logic [7:0]                 sum_q;
	logic [7:0]                 func_q;
	logic [HEAD_DEPTH-1:0][7:0] head_q;
	logic                       accept;

	assign accept = in_valid && in_ready;

	// Next phase of the hunt.
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_IDLE:    phase_d = (rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_IDLE;
				PH_SYNC2:   phase_d = (rx_byte == SYNC_BYTE) ? PH_FUNC : PH_IDLE;
				PH_FUNC:    phase_d = (rx_byte < FUNC_LIMIT) ? PH_LEN : PH_IDLE;
				PH_LEN:     phase_d = (rx_byte <= MAX_LEN) ? PH_PAYLOAD : PH_IDLE;
				PH_PAYLOAD: begin
					if (remain_q == '0)
						phase_d = PH_IDLE;
					else if (remain_q == LEN_W'(1))
						phase_d = PH_CHECK;
				end
				PH_CHECK:   phase_d = PH_IDLE;
				default:    phase_d = PH_IDLE;
			endcase
		end
	end

	// Hold the checksum byte while the queue has no room; push the frame when its sum matches.
	always_comb begin
		in_ready       = !(phase_q == PH_CHECK && q_full);
		push.valid     = accept && phase_q == PH_CHECK && sum_q == rx_byte;
		push.frame.func = func_q;
		push.frame.len  = index_q;
		push.frame.head = head_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			remain_q <= '0;
			index_q  <= '0;
		end else begin
			phase_q <= phase_d;
			if (accept && phase_q == PH_LEN && rx_byte <= MAX_LEN) begin
				remain_q <= rx_byte[LEN_W-1:0];
				index_q  <= '0;
			end else if (accept && phase_q == PH_PAYLOAD && remain_q != '0) begin
				remain_q <= remain_q - LEN_W'(1);
				index_q  <= index_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (phase_q)
				PH_IDLE:  sum_q <= rx_byte;
				PH_SYNC2: sum_q <= sum_q + rx_byte;
				PH_FUNC: begin
					func_q <= rx_byte;
					sum_q  <= sum_q + rx_byte;
				end
				PH_LEN: begin
					sum_q  <= sum_q + rx_byte;
					head_q <= '0;
				end
				PH_PAYLOAD: begin
					if (remain_q != '0) begin
						sum_q <= sum_q + rx_byte;
						if (index_q < LEN_W'(HEAD_DEPTH))
							head_q[index_q[HEAD_IDX_W-1:0]] <= rx_byte;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

>>> sv/fsfp_queue.sv
`include "assert_macros.svh"

module fsfp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  fsfp_pkg::push_t push,
	output logic            full,
	output fsfp_pkg::pop_t  head,
	input  logic            pop
);
	import fsfp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head.valid = count_q != '0;
	assign head.frame = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push.valid && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push.valid)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid)
			slot_q[wr_ptr_q] <= push.frame;
	end

	`ASSERT_CLK(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "frame queue count overflow")
	`ASSERT_CLK(a_no_push_full, push.valid |-> !full, "frame pushed into full queue")
	`ASSERT_CLK(a_no_pop_empty, pop |-> head.valid, "frame popped from empty queue")

endmodule

>>> sv/fsfp_back.sv
module fsfp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  fsfp_pkg::pop_t    head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output fsfp_pkg::result_t result
);
	import fsfp_pkg::*;

	logic    out_valid_q;
	result_t result_q;

	// Refill the output register when it is empty or being drained.
	assign pop       = head.valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop)
			result_q <= decode_frame(head.frame);
	end

endmodule

>>> verif/tb_top.sv
import fsfp_pkg::*;

class frame_scoreboard;
	int unsigned max_len;
	phase_t      phase;
	logic [5:0]  remaining;
	logic [5:0]  index;
	logic [7:0]  sum;
	logic [7:0]  func;
	logic [7:0]  head [HEAD_DEPTH];
	result_t     expected_q[$];
	int          n_bytes;
	int          n_checked;
	int          n_errors;
	int          kind_seen [9];

	function new(int unsigned max_len_i);
		max_len   = max_len_i;
		phase     = PH_IDLE;
		remaining = '0;
		index     = '0;
		sum       = '0;
		func      = '0;
		foreach (head[i]) head[i] = '0;
		n_bytes   = 0;
		n_checked = 0;
		n_errors  = 0;
		foreach (kind_seen[i]) kind_seen[i] = 0;
	endfunction

	function logic [15:0] word_at(int pos);
		return {head[pos], head[pos+1]};
	endfunction

	function result_t frame_fields();
		result_t    r;
		logic [7:0] sub;
		int         n;
		sub              = head[0];
		r                = '0;
		r.func_code      = func;
		r.sub_format     = sub;
		r.payload_length = index;
		r.kind           = KIND_UNKNOWN;
		if (sub <= 8'd1) begin
			case (func)
				FUNC_FLOW: begin
					r.quality = head[1];
					if (sub == 8'd0) begin
						r.kind        = KIND_RAW_FLOW;
						r.value[0]    = {{8{head[2][7]}}, head[2]};
						r.value[1]    = {{8{head[3][7]}}, head[3]};
						r.light_level = head[4];
					end else begin
						r.kind = KIND_FUSED_FLOW;
						for (int i = 0; i < 4; i++)
							r.value[i] = word_at(2 + 2 * i);
						r.light_level = head[10];
					end
				end
				FUNC_ALT: begin
					r.kind     = (sub == 8'd0) ? KIND_RAW_ALT : KIND_FUSED_ALT;
					r.value[0] = word_at(1);
				end
				FUNC_IMU: begin
					r.kind = (sub == 8'd0) ? KIND_RAW_IMU : KIND_FILT_IMU;
					for (int i = 0; i < 6; i++)
						r.value[i] = word_at(1 + 2 * i);
				end
				FUNC_ATTITUDE: begin
					r.kind = (sub == 8'd0) ? KIND_EULER : KIND_QUAT;
					n      = (sub == 8'd0) ? 3 : 4;
					for (int i = 0; i < n; i++)
						r.value[i] = word_at(1 + 2 * i);
				end
				default: r.kind = KIND_UNKNOWN;
			endcase
		end
		return r;
	endfunction

	function void note_byte(logic [7:0] b);
		n_bytes++;
		case (phase)
			PH_IDLE: begin
				if (b == SYNC_BYTE) begin
					sum   = b;
					phase = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (b == SYNC_BYTE) begin
					sum   = sum + b;
					phase = PH_FUNC;
				end else
					phase = PH_IDLE;
			end
			PH_FUNC: begin
				if (b < FUNC_LIMIT) begin
					func  = b;
					sum   = sum + b;
					phase = PH_LEN;
				end else
					phase = PH_IDLE;
			end
			PH_LEN: begin
				if (b <= max_len) begin
					sum       = sum + b;
					remaining = b[5:0];
					index     = '0;
					foreach (head[i]) head[i] = '0;
					phase     = PH_PAYLOAD;
				end else
					phase = PH_IDLE;
			end
			PH_PAYLOAD: begin
				if (remaining == '0)
					phase = PH_IDLE;
				else begin
					sum = sum + b;
					if (index < HEAD_DEPTH)
						head[index] = b;
					index     = index + 6'd1;
					remaining = remaining - 6'd1;
					if (remaining == '0)
						phase = PH_CHECK;
				end
			end
			PH_CHECK: begin
				phase = PH_IDLE;
				if (sum == b)
					expected_q.push_back(frame_fields());
			end
			default: phase = PH_IDLE;
		endcase
	endfunction

	function void check_field(string name, int want, int seen);
		if (want != seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			n_errors++;
		end
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (expected_q.size() == 0) begin
			$error("result with no frame pending: func_code %0h kind %0d",
				got.func_code, got.kind);
			n_errors++;
			return;
		end
		want = expected_q.pop_front();
		n_checked++;
		kind_seen[want.kind]++;
		check_field("func_code", want.func_code, got.func_code);
		check_field("sub_format", want.sub_format, got.sub_format);
		check_field("kind", want.kind, got.kind);
		check_field("payload_length", want.payload_length, got.payload_length);
		check_field("quality", want.quality, got.quality);
		check_field("light_level", want.light_level, got.light_level);
		for (int i = 0; i < N_VALUES; i++)
			check_field($sformatf("value%0d", i), $signed(want.value[i]),
				$signed(got.value[i]));
	endfunction
endclass

module tb_top;
	localparam int MAX_LEN        = 44;
	localparam int BYTE_TARGET    = 1200;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte   = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         func_code;
	logic [7:0]         sub_format;
	logic [3:0]         kind;
	logic [5:0]         payload_length;
	logic [7:0]         quality;
	logic [7:0]         light_level;
	logic signed [15:0] value0;
	logic signed [15:0] value1;
	logic signed [15:0] value2;
	logic signed [15:0] value3;
	logic signed [15:0] value4;
	logic signed [15:0] value5;

	frame_scoreboard sb;
	logic [7:0]      body[$];
	bit              sender_burst   = 1'b0;
	bit              receiver_burst = 1'b0;
	bit              hold_request   = 1'b0;
	int              idle_cycles    = 0;

	always #2 clk = ~clk;

	flow_sensor_frame_parser #(
		.MAX_PAYLOAD(MAX_LEN)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.func_code     (func_code),
		.sub_format    (sub_format),
		.kind          (kind),
		.payload_length(payload_length),
		.quality       (quality),
		.light_level   (light_level),
		.value0        (value0),
		.value1        (value1),
		.value2        (value2),
		.value3        (value3),
		.value4        (value4),
		.value5        (value5)
	);

	// Offer one byte request. Draw an idle gap first unless the sender is in a
	// burst; hold valid and the byte until the parser takes them, then hand the
	// byte to the predictor at the very edge that accepted it.
	task send_byte(input logic [7:0] b);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b);
	endtask

	// Wrap the current body in sync, function, length and sum bytes. Flip one
	// checksum bit when a corrupt frame is wanted. An empty body sends a zero
	// length, and the trailing byte is then the one the parser throws away.
	task send_frame(input logic [7:0] fn, input bit bad_sum);
		logic [7:0] sum;
		sum = SYNC_BYTE + SYNC_BYTE + fn + 8'(body.size());
		foreach (body[i]) sum += body[i];
		if (bad_sum)
			sum ^= 8'(1 << $urandom_range(0, 7));
		send_byte(SYNC_BYTE);
		send_byte(SYNC_BYTE);
		send_byte(fn);
		send_byte(8'(body.size()));
		foreach (body[i]) send_byte(body[i]);
		send_byte(sum);
	endtask

	// Build a payload of n bytes that opens with the sub-format byte.
	task fill_body(input int n, input logic [7:0] sub);
		body.delete();
		if (n > 0)
			body.push_back(sub);
		for (int i = 1; i < n; i++)
			body.push_back(8'($urandom_range(0, 255)));
	endtask

	// Favor the four decoded functions; leave room for any other legal one.
	function automatic logic [7:0] pick_func();
		case ($urandom_range(0, 4))
			0:       return FUNC_FLOW;
			1:       return FUNC_ALT;
			2:       return FUNC_IMU;
			3:       return FUNC_ATTITUDE;
			default: return 8'($urandom_range(0, int'(FUNC_LIMIT) - 1));
		endcase
	endfunction

	// Mostly short payloads so that frames turn over fast; now and then a
	// long one that runs past the decoded head up to the maximum length.
	task random_frame(input bit bad_sum);
		int         n;
		logic [7:0] sub;
		n   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, MAX_LEN)
			: $urandom_range(1, 14);
		sub = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 1));
		fill_body(n, sub);
		send_frame(pick_func(), bad_sum);
	endtask

	// Result side: draw a stall per request, or take a long hold-off when the
	// stimulus asks for one, then keep ready high until a result is taken.
	initial begin
		result_t got;
		int      stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = receiver_burst ? 0 : $urandom_range(0, 17);
			if (hold_request) begin
				hold_request = 1'b0;
				stall        = HOLD_CYCLES;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got                = '0;
			got.func_code      = func_code;
			got.sub_format     = sub_format;
			got.kind           = kind;
			got.payload_length = payload_length;
			got.quality        = quality;
			got.light_level    = light_level;
			got.value[0]       = value0;
			got.value[1]       = value1;
			got.value[2]       = value2;
			got.value[3]       = value3;
			got.value[4]       = value4;
			got.value[5]       = value5;
			sb.check_result(got);
			if ($urandom_range(0, 4) == 0)
				receiver_burst = ~receiver_burst;
		end
	end

	// Abort when no request moves on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int pick;
		sb = new(MAX_LEN);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Raw flow with sign-edge motion bytes and a full-scale quality byte.
		body = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'hC3};
		send_frame(FUNC_FLOW, 1'b0);
		fill_body(11, 8'h01);
		send_frame(FUNC_FLOW, 1'b0);
		fill_body(3, 8'h00);
		send_frame(FUNC_ALT, 1'b0);
		fill_body(3, 8'h01);
		send_frame(FUNC_ALT, 1'b0);
		// Inertial frame with every bit set past the sub-format byte.
		body.delete();
		body.push_back(8'h00);
		for (int i = 1; i < HEAD_DEPTH; i++) body.push_back(8'hFF);
		send_frame(FUNC_IMU, 1'b0);
		// Longest legal payload: bytes past the head only feed the sum.
		fill_body(MAX_LEN, 8'h01);
		send_frame(FUNC_IMU, 1'b0);
		fill_body(7, 8'h00);
		send_frame(FUNC_ATTITUDE, 1'b0);
		fill_body(9, 8'h01);
		send_frame(FUNC_ATTITUDE, 1'b0);
		// Short payload: missing head positions must read as zero.
		fill_body(2, 8'h01);
		send_frame(FUNC_FLOW, 1'b0);
		fill_body(1, 8'h01);
		send_frame(FUNC_ATTITUDE, 1'b0);
		// Unknown sub-format and unknown functions decode to kind unknown.
		fill_body(5, 8'h02);
		send_frame(FUNC_IMU, 1'b0);
		fill_body(3, 8'hFF);
		send_frame(FUNC_FLOW, 1'b0);
		fill_body(4, 8'h00);
		send_frame(8'h00, 1'b0);
		fill_body(4, 8'h01);
		send_frame(8'(int'(FUNC_LIMIT) - 1), 1'b0);
		// A third sync byte lands in the function slot and is legal there.
		fill_body(1, 8'h00);
		send_frame(SYNC_BYTE, 1'b0);
		// Corrupt checksum: drop the frame.
		fill_body(5, 8'h00);
		send_frame(FUNC_FLOW, 1'b1);
		// Zero length: drop the frame and the byte after it.
		body.delete();
		send_frame(FUNC_ALT, 1'b0);
		// Over-long length and out-of-range functions break the header.
		send_byte(SYNC_BYTE);
		send_byte(SYNC_BYTE);
		send_byte(FUNC_FLOW);
		send_byte(8'(MAX_LEN + 1));
		send_byte(SYNC_BYTE);
		send_byte(SYNC_BYTE);
		send_byte(FUNC_LIMIT);
		send_byte(SYNC_BYTE);
		send_byte(SYNC_BYTE);
		send_byte(8'hFF);
		// Broken sync pair; the stray byte must not count as a first sync.
		send_byte(SYNC_BYTE);
		send_byte(8'h55);
		fill_body(3, 8'h00);
		send_frame(FUNC_ALT, 1'b0);

		// Back-pressure: freeze the result side while a burst of good frames
		// goes in, so the frame queue fills and the parser stalls its input.
		hold_request = 1'b1;
		sender_burst = 1'b1;
		repeat (40) random_frame(1'b0);

		// Random traffic: mostly well-formed frames with random content, the
		// rest corrupt sums, line noise and broken headers.
		while (sb.n_bytes < BYTE_TARGET) begin
			sender_burst = ($urandom_range(0, 3) == 0);
			pick         = $urandom_range(0, 99);
			if (pick < 70)
				random_frame(1'b0);
			else if (pick < 80)
				random_frame(1'b1);
			else if (pick < 90) begin
				repeat ($urandom_range(1, 6))
					send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE
						: 8'($urandom_range(0, 255)));
			end else begin
				send_byte(SYNC_BYTE);
				case ($urandom_range(0, 2))
					0: send_byte(8'($urandom_range(0, 255)));
					1: begin
						send_byte(SYNC_BYTE);
						send_byte(8'($urandom_range(int'(FUNC_LIMIT), 255)));
					end
					default: begin
						send_byte(SYNC_BYTE);
						send_byte(pick_func());
						send_byte(8'($urandom_range(MAX_LEN + 1, 255)));
					end
				endcase
			end
		end
		in_valid <= 1'b0;

		// Drain: wait out every pending frame, then a few more cycles so a
		// stray extra result would still show up.
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("run: %0d bytes sent, %0d frames checked, %0d mismatches",
			sb.n_bytes, sb.n_checked, sb.n_errors);
		$display("frames per kind (unknown..quaternion): %0d %0d %0d %0d %0d %0d %0d %0d %0d",
			sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
			sb.kind_seen[4], sb.kind_seen[5], sb.kind_seen[6], sb.kind_seen[7],
			sb.kind_seen[8]);
		if (sb.n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
